/* hdl/e2c_pkg.sv */
package e2c_pkg;

   // pipeline shape: working stages, then the result register
   localparam int PIPE_DEPTH = 10;
   localparam int NUM_STAGES = PIPE_DEPTH + 1;

   // register indexes of the configuration port
   typedef enum logic {
      CSR_ZONE_OFFSET = 1'b0,
      CSR_ZONE_FIXED  = 1'b1
   } csr_index_type;

   // days from 0001-01-01 to 1970-01-01, as seconds
   localparam longint unsigned PRE_EPOCH_YEARS = 64'd1969;
   localparam longint unsigned EPOCH_DAYS = 64'd365 * PRE_EPOCH_YEARS + PRE_EPOCH_YEARS / 4
      - PRE_EPOCH_YEARS / 100 + PRE_EPOCH_YEARS / 400;
   localparam longint unsigned SECS_PER_DAY = 64'd86400;
   localparam logic [38:0] EPOCH_SECS = 39'(EPOCH_DAYS * SECS_PER_DAY);

   // seconds per day split as 2^7 * 675
   localparam int DAY_SHIFT = 7;
   localparam logic [31:0] DAY_DIV = 32'(SECS_PER_DAY >> DAY_SHIFT);
   localparam int DAY_RECIP_SHIFT = 41;
   localparam logic [31:0] DAY_RECIP = 32'((64'd1 << DAY_RECIP_SHIFT) / 64'd675);

   // days since 0000-03-01 and the 400-year cycle
   localparam logic [21:0] MARCH_OFFSET = 22'd306;
   localparam logic [31:0] DAYS_PER_400Y = 32'd146097;
   localparam logic [23:0] YEAR_RECIP = 24'((64'd400 << 32) / 64'd146097);

   // rounded-up reciprocals, exact over the ranges in use
   localparam logic [13:0] HOUR_RECIP = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
   localparam logic [10:0] MIN_RECIP = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
   localparam logic [11:0] MON_RECIP = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam logic [13:0] DIV25_RECIP = 14'(((64'd1 << 18) + 64'd24) / 64'd25);

   typedef struct packed {
      logic [37:0] unix_seconds;
      logic [29:0] nanoseconds;
      logic        use_local;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [2:0]  weekday;
      logic [8:0]  day_of_year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [29:0] nanoseconds_out;
   } rsp_type;

   // working fields carried down the pipeline
   typedef struct packed {
      logic               bad;
      logic               use_local;
      logic [37:0]        secs;
      logic [29:0]        nsec;
      logic [38:0]        total;
      logic [21:0]        days;
      logic [16:0]        daysec;
      logic [21:0]        d;
      logic [13:0]        y0;
      logic [2:0]         wday;
      logic [4:0]         hour;
      logic [11:0]        rem3600;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [13:0]        year;
      logic [7:0]         q100;
      logic [7:0]         q100m;
      logic signed [10:0] yd;
      logic               leap;
      logic               leapm;
      logic [3:0]         mon;
   } pipe_type;

   // remainder by 7 from sums of octal digits
   function automatic logic [2:0] mod7(input logic [23:0] v);
      logic [5:0] s;
      logic [3:0] f2;
      logic [3:0] f3;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + 6'(v[3*i +: 3]);
      end
      f2 = 4'(s[5:3]) + 4'(s[2:0]);
      f3 = 4'(f2[3]) + 4'(f2[2:0]);
      return (f3 >= 4'd7) ? 3'(f3 - 4'd7) : f3[2:0];
   endfunction

   // quotient by 25 for 12-bit values
   function automatic logic [7:0] div25(input logic [11:0] v);
      logic [25:0] p;
      p = 26'(v) * 26'(DIV25_RECIP);
      return p[25:18];
   endfunction

   // first day of a march-based month, minus one
   function automatic logic [8:0] month_base(input logic [3:0] mon);
      logic [8:0] b;
      unique case (mon)
         4'd2:    b = 9'd31;
         4'd3:    b = 9'd61;
         4'd4:    b = 9'd92;
         4'd5:    b = 9'd122;
         4'd6:    b = 9'd153;
         4'd7:    b = 9'd184;
         4'd8:    b = 9'd214;
         4'd9:    b = 9'd245;
         4'd10:   b = 9'd275;
         4'd11:   b = 9'd306;
         4'd12:   b = 9'd337;
         default: b = 9'd0;
      endcase
      return b;
   endfunction

endpackage

/* hdl/epoch_seconds_to_calendar_top.sv */
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_data (unix_seconds, nanoseconds, use_local)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_data (valid_res, date, time, nanoseconds_out)
// csr     | in        | csr_we               | csr_index, csr_wdata
//
// One request per cycle sustained while rsp is not stalled; a result passes
// through the input register, nine working stages and the result register
// on its way to rsp.
// Every stage holds its own valid bit, so bubbles fill while a result waits.
// Synchronous reset clears the valid bits and the zone registers.
module epoch_seconds_to_calendar_top
   import e2c_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [17:0]   csr_wdata
);

   logic signed [17:0]    zone_offset_ff;
   logic                  zone_fixed_ff;
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;
   pipe_type              st_ff [PIPE_DEPTH];
   pipe_type              st_in [PIPE_DEPTH];
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   // zone registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff <= '0;
         zone_fixed_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ZONE_OFFSET: zone_offset_ff <= csr_wdata;
            CSR_ZONE_FIXED:  zone_fixed_ff  <= csr_wdata[0];
            default:         zone_fixed_ff  <= zone_fixed_ff;
         endcase
      end
   end

   // a stage may load when rsp_ready is high or it or any stage after it holds a bubble
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_adv
      assign adv[i] = rsp_ready | ~(&vld_ff[NUM_STAGES-1:i]);
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
         if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
      if (adv[NUM_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   // stage logic
   always_comb begin
      logic [38:0] off_ext;
      logic [63:0] prod_day;
      logic [31:0] rem_full;
      logic        fix;
      logic [31:0] rem_lo;
      logic [21:0] d;
      logic [45:0] prod_year;
      logic [26:0] prod_hour;
      logic [31:0] t_rem;
      logic [13:0] ym1;
      logic [20:0] prod_min;
      logic [23:0] dt;
      logic [23:0] yd_full;
      logic [10:0] w;
      logic [22:0] prod_mon;
      logic [8:0]  ydu;
      logic [8:0]  mday;
      logic [13:0] year;
      logic [3:0]  mon;

      // capture the request
      st_in[0]           = '0;
      st_in[0].secs      = req_data.unix_seconds;
      st_in[0].nsec      = req_data.nanoseconds;
      st_in[0].use_local = req_data.use_local;
      st_in[0].bad       = req_data.use_local & ~zone_fixed_ff;

      // rebase to year 1 and apply the zone offset
      st_in[1]       = st_ff[0];
      off_ext        = 39'(zone_offset_ff);
      st_in[1].total = 39'({1'b0, st_ff[0].secs}) + EPOCH_SECS
                     + (st_ff[0].use_local ? off_ext : '0);

      // day estimate by reciprocal
      st_in[2]      = st_ff[1];
      prod_day      = 64'(st_ff[1].total[38:DAY_SHIFT]) * 64'(DAY_RECIP);
      st_in[2].days = prod_day[62:41];

      // day correction and seconds of day
      st_in[3]        = st_ff[2];
      rem_full        = st_ff[2].total[38:DAY_SHIFT] - 32'(st_ff[2].days) * DAY_DIV;
      fix             = (rem_full >= DAY_DIV);
      rem_lo          = fix ? (rem_full - DAY_DIV) : rem_full;
      st_in[3].days   = st_ff[2].days + 22'(fix);
      st_in[3].daysec = {rem_lo[9:0], st_ff[2].total[DAY_SHIFT-1:0]};

      // march-based day count, year estimate, weekday, hour
      st_in[4]      = st_ff[3];
      d             = st_ff[3].days + MARCH_OFFSET;
      st_in[4].d    = d;
      prod_year     = 46'(d) * 46'(YEAR_RECIP);
      st_in[4].y0   = prod_year[45:32];
      st_in[4].wday = mod7(24'(st_ff[3].days) + 24'd1);
      prod_hour     = 27'(st_ff[3].daysec[16:4]) * 27'(HOUR_RECIP);
      st_in[4].hour = prod_hour[25:21];

      // exact year and seconds within the hour
      st_in[5]         = st_ff[4];
      t_rem            = 32'(st_ff[4].d) * 32'd400 - 32'(st_ff[4].y0) * DAYS_PER_400Y;
      st_in[5].year    = st_ff[4].y0 + 14'd1 + 14'(t_rem >= DAYS_PER_400Y);
      st_in[5].rem3600 = 12'(st_ff[4].daysec - 17'(st_ff[4].hour) * 17'd3600);

      // century counts for this year and the one before, minute
      st_in[6]        = st_ff[5];
      ym1             = st_ff[5].year - 14'd1;
      st_in[6].q100   = div25(st_ff[5].year[13:2]);
      st_in[6].q100m  = div25(ym1[13:2]);
      prod_min        = 21'(st_ff[5].rem3600[11:2]) * 21'(MIN_RECIP);
      st_in[6].minute = prod_min[19:14];

      // day within the march-based year, leap flags, second
      st_in[7]  = st_ff[6];
      ym1       = st_ff[6].year - 14'd1;
      dt        = 24'(st_ff[6].year) * 24'd365 + 24'(st_ff[6].year[13:2])
                - 24'(st_ff[6].q100) + 24'(st_ff[6].q100[7:2]);
      yd_full   = 24'(st_ff[6].d) - dt;
      st_in[7].yd    = yd_full[10:0];
      st_in[7].leap  = (st_ff[6].year[1:0] == 2'd0)
                     && ((st_ff[6].year != 14'(st_ff[6].q100) * 14'd100)
                         || (st_ff[6].q100[1:0] == 2'd0));
      st_in[7].leapm = (ym1[1:0] == 2'd0)
                     && ((ym1 != 14'(st_ff[6].q100m) * 14'd100)
                         || (st_ff[6].q100m[1:0] == 2'd0));
      st_in[7].second = 6'(st_ff[6].rem3600 - 12'(st_ff[6].minute) * 12'd60);

      // step back a year when the estimate overshot
      st_in[8] = st_ff[7];
      if (st_ff[7].yd < 0) begin
         st_in[8].yd   = st_ff[7].yd + 11'sd365 + $signed(11'(st_ff[7].leap));
         st_in[8].year = st_ff[7].year - 14'd1;
         st_in[8].leap = st_ff[7].leapm;
      end

      // march-based month
      st_in[9]     = st_ff[8];
      w            = (11'(st_ff[8].yd[8:0]) + 11'd31) * 11'd5;
      prod_mon     = 23'(w) * 23'(MON_RECIP);
      st_in[9].mon = prod_mon[22:19];

      // day of month and move to january-based year
      ydu  = st_ff[9].yd[8:0];
      mday = ydu - month_base(st_ff[9].mon);
      year = st_ff[9].year;
      mon  = st_ff[9].mon;
      if (ydu >= 9'd306) begin
         year = year + 14'd1;
         mon  = mon - 4'd10;
         ydu  = ydu - 9'd306;
      end else begin
         mon  = mon + 4'd2;
         ydu  = ydu + 9'd59 + 9'(st_ff[9].leap);
      end

      // result, all zero for a refused local request
      rsp_in = '0;
      if (!st_ff[9].bad) begin
         rsp_in.valid_res       = 1'b1;
         rsp_in.year            = year;
         rsp_in.month           = mon;
         rsp_in.day_of_month    = 5'(mday + 9'd1);
         rsp_in.weekday         = st_ff[9].wday;
         rsp_in.day_of_year     = ydu + 9'd1;
         rsp_in.hour            = st_ff[9].hour;
         rsp_in.minute          = st_ff[9].minute;
         rsp_in.second          = st_ff[9].second;
         rsp_in.nanoseconds_out = st_ff[9].nsec;
      end
   end

endmodule
